@@ rtl/bta_pkg.sv @@
`default_nettype none
package bta_pkg;

  localparam int WORD_W = 21;
  localparam int PTR_W  = 22;
  localparam int REQ_W  = 21;
  localparam int ADDR_W = 20;
  localparam int STAT_W = 3;
  localparam int POL_W  = 2;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [PTR_W-1:0]  ptr_t;

  localparam word_t NIL = 21'h3FFFF;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [POL_W-1:0] FIT_FIRST = 2'd0;
  localparam logic [POL_W-1:0] FIT_NEXT  = 2'd1;
  localparam logic [POL_W-1:0] FIT_BEST  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_NOSPACE = 3'd1;
  localparam logic [STAT_W-1:0] ST_ZERO    = 3'd2;
  localparam logic [STAT_W-1:0] ST_BADADDR = 3'd3;
  localparam logic [STAT_W-1:0] ST_DOUBLE  = 3'd4;

  // Widen a stored word so it can serve as a word index.
  function automatic ptr_t to_ptr(input word_t w);
    to_ptr = {{(PTR_W-WORD_W){1'b0}}, w};
  endfunction

  // Number of words covered by a block whose header or size is w.
  function automatic ptr_t blk_words(input word_t w);
    blk_words = {{(PTR_W-WORD_W+3){1'b0}}, w[WORD_W-1:3]};
  endfunction

endpackage
`default_nettype wire

@@ rtl/bta_ram.sv @@
`default_nettype none
module bta_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 131072
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

@@ rtl/boundary_tag_heap_allocator.sv @@
`default_nettype none
// Channel  | signals                                         | handshake
// ---------+-------------------------------------------------+------------------
// in       | command, request_bytes, block_address           | in_valid/in_stall
// out      | payload_address, status                         | out_valid/out_stall
// cfg      | fit_policy                                      | cfg_valid/cfg_ready
//
// One item at a time through a single-port heap RAM. Allocate: walks the free list
// node by node, then takes and splits the block. Free: walks the blocks from the heap
// start to the freed one, then relinks it and does up to two merges. After reset a
// sweep over all HEAP_BYTES/8 heap words initializes the heap; in_stall stays high
// through it. A stalled result is held in the output register while the next item
// is already accepted.
module boundary_tag_heap_allocator #(
  parameter int HEAP_BYTES = 1048576
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         command,
  input  wire logic [bta_pkg::REQ_W-1:0]    request_bytes,
  input  wire logic [bta_pkg::ADDR_W-1:0]   block_address,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [bta_pkg::ADDR_W-1:0]        payload_address,
  output logic [bta_pkg::STAT_W-1:0]        status,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [bta_pkg::POL_W-1:0]    fit_policy
);

  import bta_pkg::*;

  localparam int HW = HEAP_BYTES / 8;
  localparam int AW = $clog2(HW);
  localparam int GW = $clog2(HW + 2);
  localparam ptr_t HW_P = PTR_W'(HW);

  localparam logic [4:0] S_CLR  = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_RV0  = 5'd2;
  localparam logic [4:0] S_RV1  = 5'd3;
  localparam logic [4:0] S_SRA  = 5'd4;
  localparam logic [4:0] S_SRB  = 5'd5;
  localparam logic [4:0] S_SRC  = 5'd6;
  localparam logic [4:0] S_TK0  = 5'd7;
  localparam logic [4:0] S_TK1  = 5'd8;
  localparam logic [4:0] S_TK2  = 5'd9;
  localparam logic [4:0] S_TK3  = 5'd10;
  localparam logic [4:0] S_WR   = 5'd11;
  localparam logic [4:0] S_FW0  = 5'd12;
  localparam logic [4:0] S_FW1  = 5'd13;
  localparam logic [4:0] S_FH   = 5'd14;
  localparam logic [4:0] S_ON0  = 5'd15;
  localparam logic [4:0] S_ON1  = 5'd16;
  localparam logic [4:0] S_FP0  = 5'd17;
  localparam logic [4:0] S_FP1  = 5'd18;
  localparam logic [4:0] S_M0   = 5'd19;
  localparam logic [4:0] S_M1   = 5'd20;
  localparam logic [4:0] S_M2   = 5'd21;
  localparam logic [4:0] S_M3   = 5'd22;
  localparam logic [4:0] S_NB0  = 5'd23;
  localparam logic [4:0] S_NB1  = 5'd24;
  localparam logic [4:0] S_NB2  = 5'd25;
  localparam logic [4:0] S_FIN  = 5'd26;
  localparam logic [4:0] S_RESP = 5'd27;

  localparam logic [2:0] PH_TNS = 3'd0;
  localparam logic [2:0] PH_TSP = 3'd1;
  localparam logic [2:0] PH_FHD = 3'd2;
  localparam logic [2:0] PH_FNP = 3'd3;
  localparam logic [2:0] PH_FPF = 3'd4;
  localparam logic [2:0] PH_MRG = 3'd5;

  logic [4:0] state;
  logic [POL_W-1:0] policy;
  word_t flh, rover;
  logic [REQ_W-1:0] req;
  ptr_t need, p, best, b, head, f, pf, mh, mt, nb;
  logic [GW-1:0] guard;
  logic fallback, best_mode, best_vld, pf_vld, mret, rd_oob;
  word_t bsz, old, nx, pv, sz, on, ts, hs, mnx;
  logic [2:0] wphase;
  logic [3:0] wstep;
  logic [AW-1:0] clr;
  logic [ADDR_W-1:0] res_addr;
  logic [STAT_W-1:0] res_status;

  ptr_t maddr;
  logic mwe;
  word_t mwd, ram_q, rdat;
  ptr_t w_addr;
  word_t w_data;
  logic w_en, w_last;
  ptr_t r_c, nb_c, bp2, need_c, sum_c;
  word_t rs_c, clr_val;

  bta_ram #(.WIDTH(WORD_W), .DEPTH(HW)) u_ram (
    .clk   (clk),
    .we    (mwe),
    .addr  (maddr[AW-1:0]),
    .wdata (mwd),
    .rdata (ram_q)
  );

  assign rdat = rd_oob ? '0 : ram_q;
  assign in_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  assign r_c  = b + {3'b0, need[PTR_W-1:3]};
  assign rs_c = old - need[WORD_W-1:0];
  assign nb_c = head + blk_words(rdat);
  assign bp2  = b + PTR_W'(2);
  assign sum_c = {1'b0, request_bytes} + PTR_W'(31);
  assign need_c = ({sum_c[PTR_W-1:3], 3'b000} < PTR_W'(32)) ? PTR_W'(32)
                                                             : {sum_c[PTR_W-1:3], 3'b000};

  always_comb begin
    clr_val = '0;
    if (clr == '0 || clr == AW'(HW - 1)) begin
      clr_val = WORD_W'(HEAP_BYTES);
    end else if (clr == AW'(1) || clr == AW'(2)) begin
      clr_val = NIL;
    end
  end

  // Write sequences: one store word per cycle, in the order the heap format needs.
  always_comb begin
    w_addr = '0;
    w_data = '0;
    w_en   = 1'b0;
    w_last = 1'b1;
    unique case (wphase)
      PH_TNS: begin
        w_last = (wstep == 4'd4);
        unique case (wstep)
          4'd0: begin w_addr = b; w_data = old | 21'd1; w_en = 1'b1; end
          4'd1: begin
            w_addr = b + blk_words(old) - PTR_W'(1); w_data = old | 21'd1; w_en = 1'b1;
          end
          4'd2: begin w_addr = to_ptr(nx) + PTR_W'(2); w_data = pv; w_en = (nx != NIL); end
          4'd3: begin w_addr = to_ptr(pv) + PTR_W'(1); w_data = nx; w_en = (pv != NIL); end
          4'd4: begin w_addr = b + PTR_W'(1); w_data = req; w_en = 1'b1; end
          default: begin w_last = 1'b1; end
        endcase
      end
      PH_TSP: begin
        w_last = (wstep == 4'd8);
        unique case (wstep)
          4'd0: begin w_addr = b; w_data = need[WORD_W-1:0] | 21'd1; w_en = 1'b1; end
          4'd1: begin
            w_addr = b + {3'b0, need[PTR_W-1:3]} - PTR_W'(1);
            w_data = need[WORD_W-1:0] | 21'd1;
            w_en = 1'b1;
          end
          4'd2: begin w_addr = r_c; w_data = rs_c; w_en = 1'b1; end
          4'd3: begin w_addr = r_c + PTR_W'(1); w_data = nx; w_en = 1'b1; end
          4'd4: begin w_addr = r_c + PTR_W'(2); w_data = pv; w_en = 1'b1; end
          4'd5: begin
            w_addr = r_c + blk_words(rs_c) - PTR_W'(1); w_data = rs_c; w_en = 1'b1;
          end
          4'd6: begin
            w_addr = to_ptr(pv) + PTR_W'(1); w_data = WORD_W'(r_c); w_en = (pv != NIL);
          end
          4'd7: begin
            w_addr = to_ptr(nx) + PTR_W'(2); w_data = WORD_W'(r_c); w_en = (nx != NIL);
          end
          4'd8: begin w_addr = b + PTR_W'(1); w_data = req; w_en = 1'b1; end
          default: begin w_last = 1'b1; end
        endcase
      end
      PH_FHD: begin
        w_last = (wstep == 4'd1);
        w_en = 1'b1;
        w_data = sz;
        w_addr = (wstep == 4'd0) ? head : head + blk_words(sz) - PTR_W'(1);
      end
      PH_FNP: begin
        w_last = (wstep == 4'd2);
        unique case (wstep)
          4'd0: begin w_addr = head + PTR_W'(1); w_data = flh; w_en = 1'b1; end
          4'd1: begin w_addr = head + PTR_W'(2); w_data = NIL; w_en = 1'b1; end
          4'd2: begin
            w_addr = to_ptr(flh) + PTR_W'(2); w_data = WORD_W'(head); w_en = (flh != NIL);
          end
          default: begin w_last = 1'b1; end
        endcase
      end
      PH_FPF: begin
        w_last = (wstep == 4'd3);
        unique case (wstep)
          4'd0: begin w_addr = pf + PTR_W'(1); w_data = WORD_W'(head); w_en = 1'b1; end
          4'd1: begin
            w_addr = to_ptr(on) + PTR_W'(2); w_data = WORD_W'(head); w_en = (on != NIL);
          end
          4'd2: begin w_addr = head + PTR_W'(1); w_data = on; w_en = 1'b1; end
          4'd3: begin w_addr = head + PTR_W'(2); w_data = WORD_W'(pf); w_en = 1'b1; end
          default: begin w_last = 1'b1; end
        endcase
      end
      PH_MRG: begin
        w_last = (wstep == 4'd3);
        unique case (wstep)
          4'd0: begin w_addr = mh; w_data = hs; w_en = 1'b1; end
          4'd1: begin
            w_addr = mt + blk_words(ts) - PTR_W'(1); w_data = hs; w_en = 1'b1;
          end
          4'd2: begin w_addr = mh + PTR_W'(1); w_data = mnx; w_en = 1'b1; end
          4'd3: begin
            w_addr = to_ptr(mnx) + PTR_W'(2); w_data = WORD_W'(mh); w_en = (mnx != NIL);
          end
          default: begin w_last = 1'b1; end
        endcase
      end
      default: begin w_last = 1'b1; end
    endcase
  end

  always_comb begin
    maddr = '0;
    mwe   = 1'b0;
    mwd   = '0;
    unique case (state)
      S_CLR: begin maddr = PTR_W'(clr); mwe = 1'b1; mwd = clr_val; end
      S_RV0: maddr = to_ptr(rover);
      S_SRA: maddr = p;
      S_SRB: maddr = p + PTR_W'(1);
      S_TK0: maddr = b;
      S_TK1: maddr = b + PTR_W'(1);
      S_TK2: maddr = b + PTR_W'(2);
      S_WR: begin maddr = w_addr; mwd = w_data; mwe = w_en && (w_addr < HW_P); end
      S_FW0: maddr = (f < head) ? f : head;
      S_ON0: maddr = pf + PTR_W'(1);
      S_FP0: maddr = pf;
      S_M0:  maddr = mt;
      S_M1:  maddr = mh;
      S_M2:  maddr = mt + PTR_W'(1);
      S_NB0: maddr = head;
      S_NB1: maddr = nb_c;
      default: maddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_oob <= (maddr >= HW_P);
    if (rst) begin
      state     <= S_CLR;
      clr       <= '0;
      policy    <= FIT_FIRST;
      flh       <= '0;
      rover     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        policy <= fit_policy;
      end
      // In S_RESP the output register is handled by that state alone.
      if (out_valid && !out_stall && state != S_RESP) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          clr <= clr + AW'(1);
          if (clr == AW'(HW - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            res_addr   <= '0;
            req        <= request_bytes;
            need       <= need_c;
            guard      <= '0;
            fallback   <= 1'b0;
            best_mode  <= (policy == FIT_BEST);
            best_vld   <= 1'b0;
            p          <= to_ptr(flh);
            if (command == CMD_ALLOC) begin
              if (request_bytes == '0) begin
                res_status <= ST_ZERO;
                state <= S_RESP;
              end else begin
                priority case (policy)
                  FIT_FIRST: begin res_status <= ST_OK; state <= S_SRA; end
                  FIT_NEXT:  begin res_status <= ST_OK; state <= S_RV0; end
                  FIT_BEST:  begin res_status <= ST_OK; state <= S_SRA; end
                  default: begin res_status <= ST_NOSPACE; state <= S_RESP; end
                endcase
              end
            end else begin
              head   <= PTR_W'(block_address[ADDR_W-1:3]) - PTR_W'(2);
              f      <= '0;
              pf_vld <= 1'b0;
              if (block_address[2:0] != 3'd0 || block_address < ADDR_W'(16) ||
                  PTR_W'(block_address[ADDR_W-1:3]) - PTR_W'(2) >= HW_P) begin
                res_status <= ST_BADADDR;
                state <= S_RESP;
              end else begin
                res_status <= ST_OK;
                state <= S_FW0;
              end
            end
          end
        end
        S_RV0: state <= S_RV1;
        S_RV1: begin
          if (to_ptr(rover) < HW_P && !rdat[0] && rdat != '0) begin
            p <= to_ptr(rover);
            fallback <= 1'b1;
          end
          state <= S_SRA;
        end
        S_SRA: begin
          if (p < HW_P && guard <= GW'(HW)) begin
            state <= S_SRB;
          end else if (best_mode) begin
            if (best_vld) begin
              b <= best;
              state <= S_TK0;
            end else begin
              res_status <= ST_NOSPACE;
              state <= S_RESP;
            end
          end else if (fallback) begin
            fallback <= 1'b0;
            p <= to_ptr(flh);
            guard <= '0;
          end else begin
            res_status <= ST_NOSPACE;
            state <= S_RESP;
          end
        end
        S_SRB: begin
          if (!rdat[0] && to_ptr(rdat) >= need && !best_mode) begin
            b <= p;
            state <= S_TK0;
          end else begin
            state <= S_SRC;
            if (!rdat[0] && to_ptr(rdat) >= need && (!best_vld || rdat < bsz)) begin
              best <= p;
              bsz <= rdat;
              best_vld <= 1'b1;
            end
          end
        end
        S_SRC: begin
          p <= to_ptr(rdat);
          guard <= guard + GW'(1);
          state <= S_SRA;
        end
        S_TK0: state <= S_TK1;
        S_TK1: begin old <= {rdat[WORD_W-1:1], 1'b0}; state <= S_TK2; end
        S_TK2: begin nx <= rdat; state <= S_TK3; end
        S_TK3: begin
          pv <= rdat;
          wstep <= '0;
          wphase <= (to_ptr(old) - need >= PTR_W'(32)) ? PH_TSP : PH_TNS;
          state <= S_WR;
        end
        S_WR: begin
          if (w_last) begin
            wstep <= '0;
            unique case (wphase)
              PH_TNS: begin
                if (pv == NIL) flh <= nx;
                rover <= nx;
                res_addr <= {bp2[ADDR_W-4:0], 3'b000};
                state <= S_RESP;
              end
              PH_TSP: begin
                if (pv == NIL) flh <= WORD_W'(r_c);
                rover <= WORD_W'(r_c);
                res_addr <= {bp2[ADDR_W-4:0], 3'b000};
                state <= S_RESP;
              end
              PH_FHD: begin
                if (pf_vld) begin
                  state <= S_ON0;
                end else begin
                  wphase <= PH_FNP;
                end
              end
              PH_FNP: begin
                flh <= WORD_W'(head);
                state <= S_NB0;
              end
              PH_FPF: state <= S_FP0;
              PH_MRG: begin
                if (mret) begin
                  state <= S_FIN;
                end else begin
                  head <= mh;
                  state <= S_NB0;
                end
              end
              default: state <= S_RESP;
            endcase
          end else begin
            wstep <= wstep + 4'd1;
          end
        end
        S_FW0: begin
          if (f < head) begin
            state <= S_FW1;
          end else if (f != head) begin
            res_status <= ST_BADADDR;
            state <= S_RESP;
          end else begin
            state <= S_FH;
          end
        end
        S_FW1: begin
          if (rdat[WORD_W-1:3] == '0) begin
            res_status <= ST_BADADDR;
            state <= S_RESP;
          end else begin
            if (!rdat[0]) begin
              pf <= f;
              pf_vld <= 1'b1;
            end
            f <= f + blk_words(rdat);
            state <= S_FW0;
          end
        end
        S_FH: begin
          if (!rdat[0]) begin
            res_status <= ST_DOUBLE;
            state <= S_RESP;
          end else begin
            sz <= {rdat[WORD_W-1:1], 1'b0};
            wphase <= PH_FHD;
            wstep <= '0;
            state <= S_WR;
          end
        end
        S_ON0: state <= S_ON1;
        S_ON1: begin
          on <= rdat;
          wphase <= PH_FPF;
          state <= S_WR;
        end
        S_FP0: state <= S_FP1;
        S_FP1: begin
          if (pf + blk_words(rdat) == head) begin
            mh <= pf;
            mt <= head;
            mret <= 1'b0;
            state <= S_M0;
          end else begin
            state <= S_NB0;
          end
        end
        S_M0: state <= S_M1;
        S_M1: begin ts <= {rdat[WORD_W-1:1], 1'b0}; state <= S_M2; end
        S_M2: begin hs <= {rdat[WORD_W-1:1], 1'b0} + ts; state <= S_M3; end
        S_M3: begin
          mnx <= rdat;
          wphase <= PH_MRG;
          wstep <= '0;
          state <= S_WR;
        end
        S_NB0: state <= S_NB1;
        S_NB1: begin
          nb <= nb_c;
          state <= (nb_c < HW_P) ? S_NB2 : S_FIN;
        end
        S_NB2: begin
          if (!rdat[0]) begin
            mh <= head;
            mt <= nb;
            mret <= 1'b1;
            state <= S_M0;
          end else begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (nb == to_ptr(rover)) rover <= WORD_W'(head);
          state <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            payload_address <= res_addr;
            status <= res_status;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
